// ===== rtl/ugbi_pkg.sv =====
// ----------------------------------------------------------------------------
// ugbi_pkg
// Shared types and constants of the uniform grid box index.
// ----------------------------------------------------------------------------
package ugbi_pkg;

  localparam int MaxInstances = 64;
  localparam int MaxCellsX    = 32;
  localparam int MaxCellsZ    = 32;
  localparam int GridCells    = MaxCellsX * MaxCellsZ;
  localparam int CellW        = $clog2(GridCells);
  localparam int AxisW        = 8;
  localparam int InstW        = 6;
  localparam int CountW       = 7;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    RK_INSERT = 2'd0,
    RK_HIT    = 2'd1,
    RK_EMPTY  = 2'd2,
    RK_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Z  = 3'd1,
    REG_CELL_SIZE = 3'd2,
    REG_CELLS_X   = 3'd3,
    REG_CELLS_Z   = 3'd4
  } reg_t;

  typedef enum logic [3:0] {
    F_IDLE, F_DIV, F_PUSH
  } fst_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CLEAR, B_WALK, B_WAIT, B_ACC, B_RESP, B_EMIT
  } bst_t;

  // request beat
  typedef struct packed {
    req_t               req_type;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_z;
  } req_beat_t;

  // result beat
  typedef struct packed {
    kind_t            result_kind;
    logic [InstW-1:0] instance_number;
    logic             table_full;
    logic             last;
  } res_beat_t;

  typedef struct packed {
    req_t             req;
    logic [AxisW-1:0] x0;
    logic [AxisW-1:0] z0;
    logic [AxisW-1:0] x1;
    logic [AxisW-1:0] z1;
    logic [AxisW-1:0] nx;
  } job_t;

  typedef struct packed {
    kind_t            kind;
    logic [InstW-1:0] num;
    logic             full;
    logic             last;
  } res_t;

endpackage

// ===== rtl/ugbi_if.sv =====
// ----------------------------------------------------------------------------
// ugbi_if
// Valid/ready channels carrying one request beat or one result beat.
// ----------------------------------------------------------------------------
interface ugbi_req_if ();
  import ugbi_pkg::*;
  logic      valid;
  logic      ready;
  req_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ugbi_res_if ();
  import ugbi_pkg::*;
  logic      valid;
  logic      ready;
  res_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ugbi_ram.sv =====
// ----------------------------------------------------------------------------
// ugbi_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module ugbi_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ugbi_front.sv =====
// ----------------------------------------------------------------------------
// ugbi_front
// Accepts requests, maps the four box corners to clamped cell coordinates
// with one shared restoring divider, and pushes a job into the queue.
// ----------------------------------------------------------------------------
module ugbi_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_req,
  input  logic signed [31:0]     in_coord [4],
  input  logic signed [31:0]     origin_x,
  input  logic signed [31:0]     origin_z,
  input  logic [30:0]            cell_size,
  input  logic [5:0]             cells_x,
  input  logic [5:0]             cells_z,
  output logic                   job_valid,
  input  logic                   job_ready,
  output ugbi_pkg::job_t         job
);
  import ugbi_pkg::*;

  fst_t               st, st_next;
  req_t               req;
  logic signed [31:0] crd [4];
  logic [1:0]         ci;
  logic [5:0]         step;
  logic [32:0]        mag;
  logic [32:0]        rem;
  logic [32:0]        quo;
  logic               neg;
  logic [30:0]        cs;
  logic [AxisW-1:0]   nx, nz;
  logic [AxisW-1:0]   corner [4];

  logic signed [32:0] diff;
  logic [33:0]        trial;
  logic [33:0]        rem_sh;
  logic [AxisW-1:0]   lim;
  logic [AxisW-1:0]   qc;
  logic [33:0]        qf;

  always_comb begin
    nx = (cells_x == 6'd0) ? AxisW'(1) :
         (cells_x > 6'(MaxCellsX)) ? AxisW'(MaxCellsX) : AxisW'(cells_x);
    nz = (cells_z == 6'd0) ? AxisW'(1) :
         (cells_z > 6'(MaxCellsZ)) ? AxisW'(MaxCellsZ) : AxisW'(cells_z);
  end

  // quotient of |d| / cs, one bit per cycle
  assign rem_sh = {rem, mag[32]};
  assign trial  = rem_sh - {3'b0, cs};

  // negatives clamp at 0; quotients above lim - 1 clamp at lim - 1
  always_comb begin
    lim = ci[0] ? nz : nx;
    qf  = {1'b0, quo};
    qc  = '0;
    if (neg) begin
      qc = '0;
    end else if (qf > 34'(lim - AxisW'(1))) begin
      qc = lim - AxisW'(1);
    end else begin
      qc = qf[AxisW-1:0];
    end
  end

  always_comb begin
    diff = ci[0] ? (33'(crd[ci]) - 33'(origin_z)) : (33'(crd[ci]) - 33'(origin_x));
  end

  assign in_ready  = (st == F_IDLE);
  assign job_valid = (st == F_PUSH);

  always_comb begin
    job.req = req;
    job.x0  = corner[0];
    job.z0  = corner[1];
    job.x1  = corner[2];
    job.z1  = corner[3];
    job.nx  = nx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      F_IDLE: begin
        if (in_valid) begin
          if (in_req == REQ_CLEAR) begin
            st_next = F_PUSH;
          end else if (in_req != REQ_NONE) begin
            st_next = F_DIV;
          end
        end
      end
      F_DIV: begin
        if (step == 6'd34 && ci == 2'd3) begin
          st_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (job_ready) begin
          st_next = F_IDLE;
        end
      end
      default: st_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      F_IDLE: begin
        req  <= req_t'(in_req);
        crd  <= in_coord;
        cs   <= (cell_size == 31'd0) ? 31'd1 : cell_size;
        ci   <= '0;
        step <= '0;
      end
      F_DIV: begin
        if (step == 6'd0) begin
          neg  <= diff[32];
          mag  <= diff[32] ? 33'(-diff) : 33'(diff);
          rem  <= '0;
          quo  <= '0;
          step <= 6'd1;
        end else if (step <= 6'd33) begin
          if (!trial[33]) begin
            rem <= trial[32:0];
            quo <= {quo[31:0], 1'b1};
          end else begin
            rem <= rem_sh[32:0];
            quo <= {quo[31:0], 1'b0};
          end
          mag  <= {mag[31:0], 1'b0};
          step <= step + 6'd1;
        end else begin
          corner[ci] <= qc;
          ci         <= ci + 2'd1;
          step       <= '0;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/ugbi_queue.sv =====
// ----------------------------------------------------------------------------
// ugbi_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module ugbi_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ugbi_pkg::job_t in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output ugbi_pkg::job_t out_job
);
  import ugbi_pkg::*;

  job_t       slot [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_job   = slot[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot[wp] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (in_valid && in_ready) begin
        wp <= ~wp;
      end
      if (out_valid && out_ready) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'((in_valid && in_ready) ? 1 : 0) - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end
endmodule

// ===== rtl/ugbi_back.sv =====
// ----------------------------------------------------------------------------
// ugbi_back
// Walks the covered cells of a job in the membership RAM: sets a bit on
// insert, ORs bitmaps on query, sweeps the RAM on clear and after reset,
// and emits results.
// ----------------------------------------------------------------------------
module ugbi_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  ugbi_pkg::job_t job,
  output logic           res_valid,
  input  logic           res_ready,
  output ugbi_pkg::res_t res,
  output logic           busy
);
  import ugbi_pkg::*;

  bst_t              st, st_next;
  job_t              cur;
  logic [AxisW-1:0]  x, z;
  logic [CellW:0]    addr_full;
  logic [CellW-1:0]  addr;
  logic [CellW-1:0]  waddr;
  logic              we;
  logic [63:0]       wdata, rdata;
  logic [63:0]       acc;
  logic [CountW-1:0] count;
  logic [InstW-1:0]  id;
  logic              full;
  logic              wr_pend;
  logic              init;
  logic [InstW-1:0]  hit_num;
  logic              hit_last;
  logic [63:0]       rest;

  ugbi_ram #(.Width(64), .Depth(GridCells)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  // cell index z * nx + x; nx is at most 32
  assign addr_full = (CellW+1)'(z) * (CellW+1)'(cur.nx) + (CellW+1)'(x);
  assign addr      = addr_full[CellW-1:0];

  assign busy      = (st != B_IDLE);
  assign job_ready = (st == B_IDLE);
  assign res_valid = (st == B_RESP) || (st == B_EMIT);

  // lowest set bit of acc and whether another remains
  always_comb begin
    hit_num = '0;
    for (int i = 63; i >= 0; i--) begin
      if (acc[i]) begin
        hit_num = InstW'(i);
      end
    end
    rest     = acc & ~(64'd1 << hit_num);
    hit_last = (rest == 64'd0);
  end

  always_comb begin
    res = '{kind: RK_CLEAR, num: '0, full: 1'b0, last: 1'b1};
    if (st == B_EMIT) begin
      res.kind = RK_HIT;
      res.num  = hit_num;
      res.last = hit_last;
    end else begin
      case (cur.req)
        REQ_CLEAR:  res.kind = RK_CLEAR;
        REQ_INSERT: begin
          res.kind = RK_INSERT;
          res.num  = full ? '0 : id;
          res.full = full;
        end
        default:    res.kind = RK_EMPTY;
      endcase
    end
  end

  // clear sweep writes zero; insert writes back read data with the bit set
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = '0;
    if (st == B_CLEAR) begin
      we    = 1'b1;
      waddr = addr;
    end else if (st == B_ACC && cur.req == REQ_INSERT && !full) begin
      we    = 1'b1;
      wdata = rdata | (64'd1 << id);
    end
  end

  // reset starts a silent sweep so every row reads zero before the first job
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= B_CLEAR;
      init <= 1'b1;
    end else begin
      st <= st_next;
      if (st_next == B_IDLE) begin
        init <= 1'b0;
      end
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      B_IDLE: begin
        if (job_valid) begin
          if (job.req == REQ_CLEAR) begin
            st_next = B_CLEAR;
          end else if (job.req == REQ_INSERT && count >= CountW'(MaxInstances)) begin
            st_next = B_RESP;
          end else if (job.x0 > job.x1 || job.z0 > job.z1) begin
            st_next = B_RESP;
          end else begin
            st_next = B_WAIT;
          end
        end
      end
      B_CLEAR: begin
        if (addr == CellW'(GridCells - 1)) begin
          st_next = init ? B_IDLE : B_RESP;
        end
      end
      B_WAIT:  st_next = B_ACC;
      B_ACC: begin
        if (wr_pend) begin
          if (cur.req == REQ_QUERY && (acc | rdata) != 64'd0) begin
            st_next = B_EMIT;
          end else begin
            st_next = B_RESP;
          end
        end else begin
          st_next = B_WAIT;
        end
      end
      B_RESP: begin
        if (res_ready) begin
          st_next = B_IDLE;
        end
      end
      B_EMIT: begin
        if (res_ready && hit_last) begin
          st_next = B_IDLE;
        end
      end
      default: st_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (st == B_CLEAR && st_next == B_RESP) begin
      count <= '0;
    end else if (st == B_IDLE && st_next != B_IDLE && job.req == REQ_INSERT &&
                 count < CountW'(MaxInstances)) begin
      count <= count + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '{req: REQ_CLEAR, x0: '0, z0: '0, x1: '0, z1: '0,
               nx: AxisW'(MaxCellsX)};
      x   <= '0;
      z   <= '0;
    end else begin
      case (st)
        B_IDLE: begin
          cur.req <= job.req;
          cur.x0  <= job.x0;
          cur.z0  <= job.z0;
          cur.x1  <= job.x1;
          cur.z1  <= job.z1;
          cur.nx  <= (job.req == REQ_CLEAR) ? AxisW'(MaxCellsX) : job.nx;
          x       <= (job.req == REQ_CLEAR) ? '0 : job.x0;
          z       <= (job.req == REQ_CLEAR) ? '0 : job.z0;
          acc     <= '0;
          id      <= count[InstW-1:0];
          full    <= (job.req == REQ_INSERT) && (count >= CountW'(MaxInstances));
          wr_pend <= (job.req != REQ_CLEAR) && job.x0 == job.x1 && job.z0 == job.z1;
        end
        B_CLEAR: begin
          if (x == AxisW'(MaxCellsX - 1)) begin
            x <= '0;
            z <= z + AxisW'(1);
          end else begin
            x <= x + AxisW'(1);
          end
        end
        B_ACC: begin
          if (cur.req == REQ_QUERY) begin
            acc <= acc | rdata;
          end
          if (!wr_pend) begin
            if (x == cur.x1) begin
              x <= cur.x0;
              z <= z + AxisW'(1);
            end else begin
              x <= x + AxisW'(1);
            end
            wr_pend <= (x == cur.x1) ? ((z + AxisW'(1)) == cur.z1 && cur.x0 == cur.x1)
                                     : ((x + AxisW'(1)) == cur.x1 && z == cur.z1);
          end
        end
        B_EMIT: begin
          if (res_ready) begin
            acc <= rest;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/uniform_grid_box_index_unit.sv =====
// ----------------------------------------------------------------------------
// uniform_grid_box_index_unit
// 2D uniform grid index over boxes with an APB register port.
// ----------------------------------------------------------------------------
// Usage: requests come in on req_in (valid/ready), results leave on res_out.
// A front part converts the four box corners to cell coordinates with one
// shared divider, one corner after another; it takes no new insert or query
// until the job is pushed (accept, divide, push). Clear and type 3 skip the
// divider. A two-entry queue lets the next request divide while the back
// part walks covered cells in the membership RAM, each cell by a registered
// read, then a write or OR. A clear sweeps all 1024 RAM rows, one a cycle.
// A query emits one beat per hit, lowest number first, with last on the
// final beat; an empty query, insert or clear gives one beat. Type 3 is
// dropped. At reset the back part sweeps the RAM to zero; requests taken
// meanwhile wait in the queue.
// When the receiver stalls the result beat holds and the queue backs up
// into the front part, which then stops taking requests.
// Registers are to be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module uniform_grid_box_index_unit (
  input  logic        clk,
  input  logic        rst,
  ugbi_req_if.sink    req_in,
  ugbi_res_if.source  res_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ugbi_pkg::*;

  logic signed [31:0] origin_x, origin_z;
  logic [30:0]        cell_size;
  logic [5:0]         cells_x, cells_z;
  logic signed [31:0] coord [4];
  logic               fq_valid, fq_ready, qb_valid, qb_ready;
  job_t               fq_job, qb_job;
  logic               busy;
  logic               wr;
  reg_t               ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_z  <= '0;
      cell_size <= 31'd256;
      cells_x   <= 6'd32;
      cells_z   <= 6'd32;
    end else if (wr) begin
      case (ridx)
        REG_ORIGIN_X:  origin_x  <= pwdata;
        REG_ORIGIN_Z:  origin_z  <= pwdata;
        REG_CELL_SIZE: cell_size <= pwdata[30:0];
        REG_CELLS_X:   cells_x   <= pwdata[5:0];
        REG_CELLS_Z:   cells_z   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ORIGIN_X:  prdata = origin_x;
      REG_ORIGIN_Z:  prdata = origin_z;
      REG_CELL_SIZE: prdata = {1'b0, cell_size};
      REG_CELLS_X:   prdata = {26'd0, cells_x};
      REG_CELLS_Z:   prdata = {26'd0, cells_z};
      default:       prdata = '0;
    endcase
  end

  assign coord[0] = req_in.data.box_min_x;
  assign coord[1] = req_in.data.box_min_z;
  assign coord[2] = req_in.data.box_max_x;
  assign coord[3] = req_in.data.box_max_z;

  ugbi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_in.valid),
    .in_ready  (req_in.ready),
    .in_req    (req_in.data.req_type),
    .in_coord  (coord),
    .origin_x  (origin_x),
    .origin_z  (origin_z),
    .cell_size (cell_size),
    .cells_x   (cells_x),
    .cells_z   (cells_z),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  ugbi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  res_t res;

  ugbi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .res_valid (res_out.valid),
    .res_ready (res_out.ready),
    .res       (res),
    .busy      (busy)
  );

  assign res_out.data.result_kind     = res.kind;
  assign res_out.data.instance_number = res.num;
  assign res_out.data.table_full      = res.full;
  assign res_out.data.last            = res.last;

`ifndef ASSERT_OFF
  a_full_num: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && res.full |-> res.num == '0 && res.kind == RK_INSERT)
    else $error("full insert carries a number");
  a_idle_no_res: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !res_out.valid)
    else $error("result while back part idle");
  a_q_hold: assert property (@(posedge clk) disable iff (rst)
    qb_valid && !qb_ready |=> qb_valid)
    else $error("queue dropped a job");
`endif
endmodule
